// ===== design/assert_macros.svh =====
// Assertion macros shared by the overlap pair finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define AOPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define AOPF_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define AOPF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/aopf_pkg.sv =====
// Package: shared types and constants of the overlap pair finder.
`default_nettype none

package aopf_pkg;

    localparam int MAX_BOXES_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int ID_W       = 32;
    localparam int COORD_IN_W = 32;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_FETCH_A,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== design/aopf_if.sv =====
// Interfaces: request, result and configuration channels.
`default_nettype none

interface aopf_req_if;
    import aopf_pkg::*;

    logic                   valid;
    logic                   ready;
    req_type_t              req_type;
    logic [INDEX_W-1:0]     index;
    logic [ID_W-1:0]        box_id;
    logic signed [COORD_IN_W-1:0] box_min_x;
    logic signed [COORD_IN_W-1:0] box_max_x;
    logic signed [COORD_IN_W-1:0] box_min_y;
    logic signed [COORD_IN_W-1:0] box_max_y;
    logic signed [COORD_IN_W-1:0] box_min_z;
    logic signed [COORD_IN_W-1:0] box_max_z;

    modport source (output valid, req_type, index, box_id, box_min_x, box_max_x,
                    box_min_y, box_max_y, box_min_z, box_max_z, input ready);
    modport sink   (input valid, req_type, index, box_id, box_min_x, box_max_x,
                    box_min_y, box_max_y, box_min_z, box_max_z, output ready);
endinterface

interface aopf_rsp_if;
    import aopf_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic            found;
    logic            last;

    modport source (output valid, first_id, second_id, found, last, input ready);
    modport sink   (input valid, first_id, second_id, found, last, output ready);
endinterface

interface aopf_cfg_if;
    import aopf_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] box_count;

    modport source (output valid, box_count, input ready);
    modport sink   (input valid, box_count, output ready);
endinterface

`default_nettype wire

// ===== design/aopf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module aopf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/aabb_overlap_pair_finder_core.sv =====
// Top level: broad-phase box overlap pair finder over a stored box table.
// Write word: stored at the edge that accepts it; no result word.
// Query word for slot i with n = min(box_count, MAX_BOXES) boxes: fetch box i, then scan boxes
// i+1 .. n-1, one tester compare per RAM read, then a flush state; ready again after that.
// Throughput is set by the single RAM read port: one stored box per cycle, bar result stalls.
// Reset clears control, box_count and the result valid flag; the box table is not cleared.
`default_nettype none

`include "assert_macros.svh"

module aabb_overlap_pair_finder_core #(
    parameter int MAX_BOXES   = aopf_pkg::MAX_BOXES_DEF,
    parameter int COORD_WIDTH = aopf_pkg::COORD_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aopf_req_if.sink   req,
    aopf_rsp_if.source rsp,
    aopf_cfg_if.sink   cfg
);

    import aopf_pkg::*;

    // Stored bound width: inputs are 32 bits, so wider settings are capped there.
    localparam int CW     = (COORD_WIDTH < COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;
    localparam int ADDR_W = $clog2(MAX_BOXES);
    // Counter width holds both the 7-bit register and MAX_BOXES itself.
    localparam int CNT_W  = ($clog2(MAX_BOXES + 1) > COUNT_W) ? $clog2(MAX_BOXES + 1)
                                                               : COUNT_W;
    localparam int BND_W  = 6 * CW;
    localparam int ENT_W  = ID_W + BND_W;

    // ------------------------------------------------------------------
    // Configuration: box_count, capped to the table size for the search.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] box_count_reg;
    logic [CNT_W-1:0]   count_ext;
    logic [CNT_W-1:0]   cnt_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            box_count_reg <= cfg.box_count;
        end
    end

    assign count_ext = CNT_W'(box_count_reg);
    assign cnt_eff   = (count_ext > CNT_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : count_ext;

    // ------------------------------------------------------------------
    // Sequencer state and the scan datapath registers.
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   j_reg, j_next;          // next slot to read
    logic               pend_reg, pend_next;    // RAM read data holds box j-1
    logic               hold_valid_reg, hold_valid_next;
    logic [ID_W-1:0]    hold_id_reg, hold_id_next;  // latest hit, not yet known last
    logic [ID_W-1:0]    a_id_reg;
    logic [BND_W-1:0]   a_bnd_reg;
    logic               a_load;

    // Result register, parts the scan from the result channel.
    logic               rsp_valid_reg;
    logic [ID_W-1:0]    first_id_reg;
    logic [ID_W-1:0]    second_id_reg;
    logic               found_reg;
    logic               last_reg;
    logic               out_free;
    logic               push;
    logic [ID_W-1:0]    push_first;
    logic [ID_W-1:0]    push_second;
    logic               push_found;
    logic               push_last;

    // Request decode
    logic               req_fire;
    logic [CNT_W-1:0]   idx_ext;
    logic               wr_en;
    logic [ENT_W-1:0]   wr_data;

    // RAM read side
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENT_W-1:0]   rd_data;
    logic [ID_W-1:0]    b_id;

    // Shared overlap tester
    logic signed [CW-1:0] a_lo [3];
    logic signed [CW-1:0] a_hi [3];
    logic signed [CW-1:0] b_lo [3];
    logic signed [CW-1:0] b_hi [3];
    logic               overlap;
    logic               hit;
    logic               stall;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign idx_ext   = CNT_W'(req.index);

    // Writes beyond the table are dropped.
    assign wr_en   = req_fire && (req.req_type == REQ_WRITE) && (idx_ext < CNT_W'(MAX_BOXES));
    // Entry layout, high to low: id, min_x, max_x, min_y, max_y, min_z, max_z.
    assign wr_data = {req.box_id,
                      req.box_min_x[CW-1:0], req.box_max_x[CW-1:0],
                      req.box_min_y[CW-1:0], req.box_max_y[CW-1:0],
                      req.box_min_z[CW-1:0], req.box_max_z[CW-1:0]};

    aopf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign b_id = rd_data[ENT_W-1 -: ID_W];

    // Inclusive test on all three axes: min_j <= max_i and max_j >= min_i.
    always_comb
    begin
        overlap = 1'b1;
        for (int ax = 0; ax < 3; ax++)
        begin
            a_lo[ax] = $signed(a_bnd_reg[(5 - 2 * ax) * CW +: CW]);
            a_hi[ax] = $signed(a_bnd_reg[(4 - 2 * ax) * CW +: CW]);
            b_lo[ax] = $signed(rd_data[(5 - 2 * ax) * CW +: CW]);
            b_hi[ax] = $signed(rd_data[(4 - 2 * ax) * CW +: CW]);
            if ((b_lo[ax] > a_hi[ax]) || (b_hi[ax] < a_lo[ax]))
            begin
                overlap = 1'b0;
            end
        end
    end

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign hit      = pend_reg && (state_reg == ST_SCAN) && overlap;
    // A new hit must move the held one out; wait if the result register is busy.
    assign stall    = hit && hold_valid_reg && !out_free;

    // ------------------------------------------------------------------
    // Sequencer: fetch box i, stream boxes i+1 .. n-1 through the tester,
    // keep the latest hit back one step so that its last flag is known.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        a_load          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = j_reg[ADDR_W-1:0];
        push            = 1'b0;
        push_first      = a_id_reg;
        push_second     = hold_id_reg;
        push_found      = 1'b1;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_QUERY))
                begin
                    hold_valid_next = 1'b0;
                    rd_en           = 1'b1;
                    rd_addr         = idx_ext[ADDR_W-1:0];
                    if (idx_ext < cnt_eff)
                    begin
                        j_next     = idx_ext + CNT_W'(1);
                        state_next = ST_FETCH_A;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FETCH_A:
            begin
                a_load = 1'b1;
                if (j_reg < cnt_eff)
                begin
                    rd_en      = 1'b1;
                    j_next     = j_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        push            = hold_valid_reg;
                        hold_id_next    = b_id;
                        hold_valid_next = 1'b1;
                    end
                    if (j_reg < cnt_eff)
                    begin
                        rd_en     = 1'b1;
                        j_next    = j_reg + CNT_W'(1);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    push_found      = hold_valid_reg;
                    push_first      = hold_valid_reg ? a_id_reg : '0;
                    push_second     = hold_valid_reg ? hold_id_reg : '0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            j_reg          <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= push || (rsp_valid_reg && !rsp.ready);
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        hold_id_reg <= hold_id_next;
        if (a_load)
        begin
            a_id_reg  <= b_id;
            a_bnd_reg <= rd_data[BND_W-1:0];
        end
        if (push)
        begin
            first_id_reg  <= push_first;
            second_id_reg <= push_second;
            found_reg     <= push_found;
            last_reg      <= push_last;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.first_id  = first_id_reg;
    assign rsp.second_id = second_id_reg;
    assign rsp.found     = found_reg;
    assign rsp.last      = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AOPF_ASSERT_IMPLY(a_pend_in_scan, pend_reg, state_reg == ST_SCAN,
        "read data marked pending outside the scan")
    `AOPF_ASSERT_IMPLY(a_hold_in_query, hold_valid_reg,
        (state_reg == ST_SCAN) || (state_reg == ST_FLUSH),
        "held hit left over outside a query")
    `AOPF_ASSERT_NEXT(a_stall_holds_scan, stall, $stable(j_reg) && pend_reg,
        "scan advanced during a result stall")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the box overlap pair finder: random and directed words, scoreboard check.
`default_nettype none

module tb;
    import aopf_pkg::*;

    // Stop if no word moves on any channel for this many cycles.
    localparam int QUIET_LIMIT = 2000;
    // Idle cycles after the last result before touching box_count.
    localparam int CFG_GUARD = 8;
    // Drain at the end: room for one full query scan plus margin.
    localparam int END_DRAIN = 80;
    // Cap on printed mismatch lines; all of them are still counted.
    localparam int PRINT_CAP = 40;

    localparam logic signed [COORD_IN_W-1:0] UNIT     = 32'sh0001_0000;
    localparam logic signed [COORD_IN_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [COORD_IN_W-1:0] MOST_POS = 32'sh7fff_ffff;

    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic signed [COORD_IN_W-1:0] min_x;
        logic signed [COORD_IN_W-1:0] max_x;
        logic signed [COORD_IN_W-1:0] min_y;
        logic signed [COORD_IN_W-1:0] max_y;
        logic signed [COORD_IN_W-1:0] min_z;
        logic signed [COORD_IN_W-1:0] max_z;
    } box_t;

    typedef struct packed {
        req_type_t          kind;
        logic [INDEX_W-1:0] slot;
        box_t               box;
    } box_req_t;

    typedef struct packed {
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic            found;
        logic            last;
    } pair_t;

    logic clk;
    logic rst_n;

    aopf_req_if req_if();
    aopf_rsp_if rsp_if();
    aopf_cfg_if cfg_if();

    aabb_overlap_pair_finder_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Request words waiting for the driver, in issue order.
    box_req_t box_req_q[$];
    // Pair words predicted but not yet seen on the result channel.
    pair_t    pending_pairs[$];

    // Predictor state: shadow box table and the live box_count.
    box_t                box_mem [MAX_BOXES_DEF];
    logic [COUNT_W-1:0]  box_limit;

    // Generator-side record of which slots will hold a box once the queue drains.
    bit slot_filled [MAX_BOXES_DEF];

    bit       src_idle_on;
    bit       snk_idle_on;
    int       src_gap;
    int       snk_stall;
    int       quiet_cycles;
    int       mismatch_count;
    box_req_t nxt;
    pair_t    want;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Inclusive interval test on one axis.
    function automatic bit spans_meet(input logic signed [COORD_IN_W-1:0] a_lo,
                                      input logic signed [COORD_IN_W-1:0] a_hi,
                                      input logic signed [COORD_IN_W-1:0] b_lo,
                                      input logic signed [COORD_IN_W-1:0] b_hi);
        return (b_lo <= a_hi) && (b_hi >= a_lo);
    endfunction

    // Walk every later live slot against the queried one and queue the pair words.
    // No hit, or slot past the live count: a single found=0 word with last set.
    task automatic find_pairs(input logic [INDEX_W-1:0] at);
        int    span;
        int    hits;
        box_t  a;
        box_t  b;
        pair_t hit;
        span = (box_limit > MAX_BOXES_DEF) ? MAX_BOXES_DEF : int'(box_limit);
        hits = 0;
        hit  = '0;
        if (int'(at) < span)
        begin
            a = box_mem[at];
            for (int j = int'(at) + 1; j < span; j++)
            begin
                b = box_mem[j];
                if (spans_meet(a.min_x, a.max_x, b.min_x, b.max_x) &&
                    spans_meet(a.min_y, a.max_y, b.min_y, b.max_y) &&
                    spans_meet(a.min_z, a.max_z, b.min_z, b.max_z))
                begin
                    if (hits > 0)
                        pending_pairs.insert(pending_pairs.size(), hit);
                    hit = '{first_id: a.id, second_id: b.id, found: 1'b1, last: 1'b0};
                    hits++;
                end
            end
        end
        if (hits == 0)
            hit = '{first_id: '0, second_id: '0, found: 1'b0, last: 1'b1};
        else
            hit.last = 1'b1;
        pending_pairs.insert(pending_pairs.size(), hit);
    endtask

    // Bounds for one axis. Mostly clustered near the origin so that boxes
    // overlap often; the rest are full-range, extreme, degenerate or inverted.
    function automatic void rand_span(output logic signed [COORD_IN_W-1:0] lo,
                                      output logic signed [COORD_IN_W-1:0] hi);
        int mode;
        int c;
        int h;
        mode = $urandom_range(0, 19);
        c = (int'($urandom_range(0, 12)) - 6) * 65536 + int'($urandom_range(0, 65535));
        h = int'($urandom_range(0, 3 * 65536));
        if (mode < 14)
        begin
            lo = c - h;
            hi = c + h;
        end
        else if (mode < 17)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (mode == 17)
        begin
            lo = MOST_NEG;
            hi = MOST_POS;
        end
        else if (mode == 18)
        begin
            lo = c;
            hi = c;
        end
        else
        begin
            lo = c + h;
            hi = c - h;
        end
    endfunction

    function automatic box_t rand_box();
        box_t bx;
        logic signed [COORD_IN_W-1:0] lo;
        logic signed [COORD_IN_W-1:0] hi;
        bx.id = $urandom;
        rand_span(lo, hi);
        bx.min_x = lo;
        bx.max_x = hi;
        rand_span(lo, hi);
        bx.min_y = lo;
        bx.max_y = hi;
        rand_span(lo, hi);
        bx.min_z = lo;
        bx.max_z = hi;
        return bx;
    endfunction

    function automatic box_t mk_box(input logic [ID_W-1:0] id,
                                    input logic signed [COORD_IN_W-1:0] x0,
                                    input logic signed [COORD_IN_W-1:0] x1,
                                    input logic signed [COORD_IN_W-1:0] y0,
                                    input logic signed [COORD_IN_W-1:0] y1,
                                    input logic signed [COORD_IN_W-1:0] z0,
                                    input logic signed [COORD_IN_W-1:0] z1);
        return '{id: id, min_x: x0, max_x: x1, min_y: y0, max_y: y1, min_z: z0, max_z: z1};
    endfunction

    task automatic push_write(input logic [INDEX_W-1:0] at, input box_t bx);
        box_req_t r;
        r = '{kind: REQ_WRITE, slot: at, box: bx};
        box_req_q.insert(box_req_q.size(), r);
        slot_filled[at] = 1'b1;
    endtask

    // Payload on a query is don't-care to the block; keep it random anyway.
    task automatic push_query(input logic [INDEX_W-1:0] at);
        box_req_t r;
        r = '{kind: REQ_QUERY, slot: at, box: rand_box()};
        box_req_q.insert(box_req_q.size(), r);
    endtask

    // Wait for the block to drain, then a short guard.
    task automatic settle(input int guard);
        while (box_req_q.size() != 0 || req_if.valid || pending_pairs.size() != 0)
            @(posedge clk);
        repeat (guard) @(posedge clk);
    endtask

    task automatic set_box_count(input logic [COUNT_W-1:0] n);
        @(posedge clk);
        cfg_if.box_count <= n;
        cfg_if.valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        box_limit = n;
    endtask

    // One phase: first make sure every live slot holds a box so no query ever
    // reads an unwritten entry, then a random mix of writes and queries.
    // Most queries hit a live slot; some land past the live count.
    task automatic plan_phase(input int unsigned count, input int n_words);
        int span;
        span = (count > MAX_BOXES_DEF) ? MAX_BOXES_DEF : int'(count);
        for (int s = 0; s < span; s++)
        begin
            if (!slot_filled[s])
                push_write(INDEX_W'(s), rand_box());
        end
        repeat (n_words)
        begin
            if ($urandom_range(0, 99) < 35)
                push_write(INDEX_W'($urandom_range(0, MAX_BOXES_DEF - 1)), rand_box());
            else if (span != 0 && $urandom_range(0, 99) < 85)
                push_query(INDEX_W'($urandom_range(0, span - 1)));
            else
                push_query(INDEX_W'($urandom_range(0, MAX_BOXES_DEF - 1)));
        end
    endtask

    // Request driver. The predictor runs at the accepting edge, so the shadow
    // table and the expected pair words follow the block's own word order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid     <= 1'b0;
            req_if.req_type  <= REQ_WRITE;
            req_if.index     <= '0;
            req_if.box_id    <= '0;
            req_if.box_min_x <= '0;
            req_if.box_max_x <= '0;
            req_if.box_min_y <= '0;
            req_if.box_max_y <= '0;
            req_if.box_min_z <= '0;
            req_if.box_max_z <= '0;
            src_gap          <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                if (req_if.req_type == REQ_WRITE)
                    box_mem[req_if.index] = '{id: req_if.box_id,
                                              min_x: req_if.box_min_x,
                                              max_x: req_if.box_max_x,
                                              min_y: req_if.box_min_y,
                                              max_y: req_if.box_max_y,
                                              min_z: req_if.box_min_z,
                                              max_z: req_if.box_max_z};
                else
                    find_pairs(req_if.index);
            end
            // Channel free after this edge: idle, start a gap burst, or send.
            if (!req_if.valid || req_if.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap      <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end
                else if (src_idle_on && box_req_q.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    src_gap      <= $urandom_range(1, 18) - 1;
                    req_if.valid <= 1'b0;
                end
                else if (box_req_q.size() != 0)
                begin
                    nxt = box_req_q.pop_front();
                    req_if.req_type  <= nxt.kind;
                    req_if.index     <= nxt.slot;
                    req_if.box_id    <= nxt.box.id;
                    req_if.box_min_x <= nxt.box.min_x;
                    req_if.box_max_x <= nxt.box.max_x;
                    req_if.box_min_y <= nxt.box.min_y;
                    req_if.box_max_y <= nxt.box.max_y;
                    req_if.box_min_z <= nxt.box.min_z;
                    req_if.box_max_z <= nxt.box.max_z;
                    req_if.valid     <= 1'b1;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word against the oldest prediction
    // and applies random back-pressure in bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            snk_stall    <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_pairs.size() == 0)
                    report_mismatch($sformatf("unexpected word first_id=%h second_id=%h",
                                              rsp_if.first_id, rsp_if.second_id));
                else
                begin
                    want = pending_pairs.pop_front();
                    if (rsp_if.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  rsp_if.found, want.found));
                    if (rsp_if.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  rsp_if.last, want.last));
                    if (rsp_if.first_id !== want.first_id)
                        report_mismatch($sformatf("first_id %h, expected %h",
                                                  rsp_if.first_id, want.first_id));
                    if (rsp_if.second_id !== want.second_id)
                        report_mismatch($sformatf("second_id %h, expected %h",
                                                  rsp_if.second_id, want.second_id));
                end
            end
            if (snk_stall != 0)
            begin
                snk_stall    <= snk_stall - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                snk_stall    <= $urandom_range(1, 18) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Watchdog: any accepted word on any channel resets the quiet count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned phase_counts [8];
        bit          closing;

        // Config inputs are known from time zero; the driver and the monitor
        // clear their own channels while reset is held.
        rst_n            <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.box_count <= '0;
        box_limit      = '0;
        mismatch_count = 0;
        src_idle_on    = 1'b1;
        snk_idle_on    = 1'b1;
        foreach (slot_filled[s])
            slot_filled[s] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: box_count is 0 out of reset, so any query is out of range.
        push_query(0);
        push_query(INDEX_W'(MAX_BOXES_DEF - 1));
        settle(CFG_GUARD);

        // Directed: hand-built boxes around the unit cube.
        //  slot 1 touches slot 0 exactly on its +x face (inclusive test);
        //  slot 2 spans the whole coordinate range;
        //  slots 3, 4, 5 miss slot 0 by one LSB on x, y, z respectively;
        //  slot 6 is inverted (min > max) on every axis;
        //  ids cover all-ones, zero, sign bit and mixed patterns.
        set_box_count(7);
        push_write(0, mk_box(32'hffff_ffff, -UNIT, UNIT, -UNIT, UNIT, -UNIT, UNIT));
        push_write(1, mk_box(32'h0000_0000, UNIT, 2 * UNIT, -UNIT, UNIT, -UNIT, UNIT));
        push_write(2, mk_box(32'h8000_0000, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS,
                             MOST_NEG, MOST_POS));
        push_write(3, mk_box(32'h1234_5678, UNIT + 1, 2 * UNIT, -UNIT, UNIT, -UNIT, UNIT));
        push_write(4, mk_box(32'h0000_ffff, -UNIT, UNIT, -3 * UNIT, -UNIT - 1,
                             -UNIT, UNIT));
        push_write(5, mk_box(32'hffff_0000, -UNIT, UNIT, -UNIT, UNIT, UNIT + 1, 3 * UNIT));
        push_write(6, mk_box(32'h5a5a_5a5a, UNIT, -UNIT, UNIT, -UNIT, UNIT, -UNIT));
        push_write(INDEX_W'(MAX_BOXES_DEF - 1), rand_box());
        for (int q = 0; q < 8; q++)
            push_query(INDEX_W'(q));
        push_query(INDEX_W'(MAX_BOXES_DEF - 1));

        // Random phases. 127 and 65 clamp to the table size; 0 and 1 leave
        // every query empty; the big phase fills the whole table first.
        phase_counts[0] = 127;
        phase_counts[1] = 0;
        phase_counts[2] = 1;
        phase_counts[3] = 2;
        phase_counts[4] = 65;
        phase_counts[5] = $urandom_range(3, 20);
        phase_counts[6] = $urandom_range(0, 127);
        phase_counts[7] = MAX_BOXES_DEF;
        foreach (phase_counts[p])
        begin
            settle(CFG_GUARD);
            set_box_count(COUNT_W'(phase_counts[p]));
            // Some phases run without idling; the closing phase never idles.
            closing     = (p == 7);
            src_idle_on = !closing && $urandom_range(0, 3) != 0;
            snk_idle_on = !closing && $urandom_range(0, 3) != 0;
            plan_phase(phase_counts[p], 7);
        end

        settle(END_DRAIN);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
